// ----- sv/aesalt_pkg.sv -----
// ----------------------------------------------------------------------------
// aesalt_pkg
// Shared constants and field helpers for the AES-128 core over GF(2^8) mod 0x1E7.
// ----------------------------------------------------------------------------
package aesalt_pkg;

    localparam int ROUNDS_DEF    = 10;
    localparam int KEY_WORDS_DEF = 4;
    localparam logic [7:0] POLY_LOW = 8'hE7;

    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = a[7] ? ({a[6:0], 1'b0} ^ POLY_LOW) : {a[6:0], 1'b0};
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xtime(x);
        end
        gf_mul = p;
    endfunction

    // Field inverse by extended Euclid over GF(2)[x]; quotients are cut to 8 bits
    // before the multiply and the last value reached is used as is.
    // Evaluated only at elaboration to build the tables below.
    function automatic logic [7:0] gf_inv_calc(input logic [7:0] b);
        logic [15:0] r0, r1, r2, q, a;
        logic [7:0]  w0, w1, w2;
        int db, da, sh, guard;
        if (b == 8'h00) return 8'h00;
        r0 = 16'h01E7; r1 = {8'h00, b}; w0 = 8'h00; w1 = 8'h01;
        w2 = 8'h00; r2 = 16'h0; q = 16'h0; a = 16'h0;
        for (guard = 0; guard < 16; guard++) begin
            db = 0;
            for (int d = 0; d < 15; d++) if ((r1 >> (d + 1)) != 0) db = d + 1;
            q = 16'h0; a = r0;
            for (int s = 0; s < 16; s++) begin
                if (a >= r1) begin
                    da = 0;
                    for (int d = 0; d < 15; d++) if ((a >> (d + 1)) != 0) da = d + 1;
                    sh = da - db;
                    q = q | (16'h1 << sh);
                    a = a ^ (r1 << sh);
                end
            end
            r2 = a;
            w2 = w0 ^ gf_mul(q[7:0], w1);
            if (r2 == 16'h0) return w1;
            r0 = r1; r1 = r2; w0 = w1; w1 = w2;
        end
        return w1;
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] a, r;
        a = gf_inv_calc(x);
        for (int i = 0; i < 8; i++)
            r[i] = a[i] ^ a[(i + 4) % 8] ^ a[(i + 5) % 8] ^ a[(i + 6) % 8]
                 ^ a[(i + 7) % 8] ^ ((8'h63 >> i) & 8'h01) != 0;
        return r;
    endfunction

    function automatic logic [7:0] isbox_calc(input logic [7:0] x);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
            r[i] = x[(i + 2) % 8] ^ x[(i + 5) % 8] ^ x[(i + 7) % 8]
                 ^ (((8'h05 >> i) & 8'h01) != 0);
        return gf_inv_calc(r);
    endfunction

    typedef logic [7:0] sbox_tab_t [256];

    function automatic sbox_tab_t make_sbox();
        sbox_tab_t t;
        for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
        return t;
    endfunction

    function automatic sbox_tab_t make_isbox();
        sbox_tab_t t;
        for (int i = 0; i < 256; i++) t[i] = isbox_calc(8'(i));
        return t;
    endfunction

    localparam sbox_tab_t SBOX  = make_sbox();
    localparam sbox_tab_t ISBOX = make_isbox();

    typedef logic [127:0] state_t;

    // Column mix of one 32-bit column, row 0 in the top byte.
    function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
        logic [7:0] a [4];
        logic [7:0] m [4];
        logic [7:0] v;
        logic [31:0] o;
        for (int j = 0; j < 4; j++) a[j] = c[31 - 8*j -: 8];
        if (inv) begin
            m[0] = 8'h0e; m[1] = 8'h0b; m[2] = 8'h0d; m[3] = 8'h09;
        end else begin
            m[0] = 8'h02; m[1] = 8'h03; m[2] = 8'h01; m[3] = 8'h01;
        end
        for (int r = 0; r < 4; r++) begin
            v = 8'h00;
            for (int j = 0; j < 4; j++) v = v ^ gf_mul(m[(j - r + 4) % 4], a[j]);
            o[31 - 8*r -: 8] = v;
        end
        return o;
    endfunction

    // Byte k of the stream sits at bits 127-8k.
    function automatic state_t shift_rows(input state_t s, input logic inv);
        state_t t;
        int src;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
                src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
                t[127 - 8*(r + 4*c) -: 8] = s[127 - 8*(r + 4*src) -: 8];
            end
        return t;
    endfunction

endpackage

// ----- sv/block_cipher_aes128_alt_field_core.sv -----
// ----------------------------------------------------------------------------
// block_cipher_aes128_alt_field_core
// AES-128 ECB encrypt/decrypt over GF(2^8) reduced by 0x1E7, round pipelined.
// ----------------------------------------------------------------------------
// Each beat on in_* carries one 16-byte block and a cmd bit (0 encrypt,
// 1 decrypt); one beat per block comes back on out_*. After reset or a key
// register write the round keys are rebuilt: the key is loaded first, then
// ten round keys are expanded in turn through one shared SubWord unit, and
// no block is taken until that is done. The datapath then runs an input
// key-add stage plus ten round stages, the last of which drives out_*.
// A new block can enter every cycle while no key write is on and out_* is not
// stalled; a stalled output freezes the whole pipeline. Round keys live in
// flip-flops, one per round, so every stage reads its own key.
module block_cipher_aes128_alt_field_core
    import aesalt_pkg::*;
#(
    parameter int ROUNDS    = ROUNDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_high,
    output logic [63:0] result_low
);

    localparam int KCW = $clog2(ROUNDS + 1);

    // key registers and expansion
    logic [63:0]  key_high_reg, key_low_reg;
    logic         keys_ready_reg;
    logic         expanding_reg;
    logic [KCW-1:0] kcnt_reg;
    logic [7:0]   rcon_reg;
    logic [127:0] rk_reg [ROUNDS+1];
    logic [127:0] kprev;
    logic [31:0]  rot, subw;
    logic [127:0] knew;

    logic adv;
    logic [ROUNDS:0] v_reg;
    logic [ROUNDS-1:0] d_reg;
    state_t st_reg [ROUNDS+1];

    function automatic state_t round_fn(input state_t x, input logic dec, input int r);
        state_t t, u;
        if (dec == CMD_ENC)
        begin
            for (int k = 0; k < 16; k++) t[8*k +: 8] = SBOX[x[8*k +: 8]];
            t = shift_rows(t, 1'b0);
            if (r != ROUNDS)
                for (int c = 0; c < 4; c++) t[32*c +: 32] = mix_col(t[32*c +: 32], 1'b0);
            u = t ^ rk_reg[KCW'(r)];
        end
        else
        begin
            t = shift_rows(x, 1'b1);
            for (int k = 0; k < 16; k++) t[8*k +: 8] = ISBOX[t[8*k +: 8]];
            t = t ^ rk_reg[KCW'(ROUNDS - r)];
            if (r != ROUNDS)
                for (int c = 0; c < 4; c++) t[32*c +: 32] = mix_col(t[32*c +: 32], 1'b1);
            u = t;
        end
        return u;
    endfunction

    assign cfg_ready = 1'b1;

    assign kprev = rk_reg[kcnt_reg];
    assign rot   = {kprev[23:0], kprev[31:24]};
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            subw[8*k +: 8] = SBOX[rot[8*k +: 8]];
        knew[127:96] = kprev[127:96] ^ subw ^ {rcon_reg, 24'h0};
        knew[95:64]  = kprev[95:64] ^ knew[127:96];
        knew[63:32]  = kprev[63:32] ^ knew[95:64];
        knew[31:0]   = kprev[31:0]  ^ knew[63:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg   <= '0;
            key_low_reg    <= '0;
            keys_ready_reg <= 1'b0;
            expanding_reg  <= 1'b0;
            kcnt_reg       <= '0;
            rcon_reg       <= 8'h01;
        end
        else if (cfg_valid)
        begin
            // the user must write these only while idle; the core does not enforce it
            case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default:      ;
            endcase
            keys_ready_reg <= 1'b0;
            expanding_reg  <= 1'b0;
        end
        else if (!keys_ready_reg && !expanding_reg)
        begin
            expanding_reg <= 1'b1;
            kcnt_reg      <= '0;
            rcon_reg      <= 8'h01;
        end
        else if (expanding_reg)
        begin
            rcon_reg <= xtime(rcon_reg);
            kcnt_reg <= kcnt_reg + 1'b1;
            if (kcnt_reg == KCW'(ROUNDS - 1))
            begin
                expanding_reg  <= 1'b0;
                keys_ready_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!keys_ready_reg && !expanding_reg && !cfg_valid)
            rk_reg[0] <= {key_high_reg, key_low_reg};
        else if (expanding_reg && !cfg_valid)
            rk_reg[kcnt_reg + 1'b1] <= knew;
    end

    // datapath pipeline; stage s holds the state after step s
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv && keys_ready_reg && !cfg_valid;
    assign out_valid   = v_reg[ROUNDS];
    assign result_high = st_reg[ROUNDS][127:64];
    assign result_low  = st_reg[ROUNDS][63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[ROUNDS-1:0], in_valid && in_ready};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg     <= {d_reg[ROUNDS-2:0], cmd};
            st_reg[0] <= {block_high, block_low} ^ (cmd ? rk_reg[ROUNDS] : rk_reg[0]);
            for (int s = 1; s <= ROUNDS; s++)
            begin
                st_reg[s] <= round_fn(st_reg[s-1], d_reg[s-1], s);
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_in_unkeyed: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> keys_ready_reg)
        else $error("block taken without expanded keys");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(result_high)))
        else $error("result lost during stall");
    a_exp_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(expanding_reg && keys_ready_reg))
        else $error("expansion while keys ready");
    a_exp_done: assert property (@(posedge clk) disable iff (!rst_n)
        (expanding_reg && kcnt_reg == KCW'(ROUNDS - 1) && !cfg_valid) |=> keys_ready_reg)
        else $error("expansion did not finish");
`endif

endmodule

// ----- tb/block_cipher_aes128_alt_field_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_cipher_aes128_alt_field_core_tb
// Self-checking bench for the AES-128 core over GF(2^8) mod 0x1E7.
// ----------------------------------------------------------------------------
// An initial block loads key registers while the core is idle and queues
// blocks for the driver. The driver presents each beat with random gaps. The
// monitor takes result beats under random back-pressure. A local cipher model
// works out every expected block when its input beat is accepted, and the
// monitor compares each result beat against the oldest expected one.
// ----------------------------------------------------------------------------
module block_cipher_aes128_alt_field_core_tb
    import aesalt_pkg::*;
;

    localparam int NUM_ROUNDS = 10;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT = 20000;
    localparam logic [8:0] FIELD_POLY = 9'h1E7;

    typedef struct packed {
        logic        op;
        logic [63:0] hi;
        logic [63:0] lo;
    } block_beat_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } cipher_out_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        cmd;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] result_high;
    logic [63:0] result_low;

    block_cipher_aes128_alt_field_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .block_high (block_high),
        .block_low  (block_low),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_high(result_high),
        .result_low (result_low)
    );

    // ---------------------------------------------------------------- model
    logic [63:0] key_hi_m;
    logic [63:0] key_lo_m;
    logic [7:0]  rk_bytes [NUM_ROUNDS + 1][16];
    bit          rk_valid;
    logic [7:0]  fwd_box [256];
    logic [7:0]  rev_box [256];

    function automatic logic [7:0] fmul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i]) p ^= a;
            a = a[7] ? ({a[6:0], 1'b0} ^ FIELD_POLY[7:0]) : {a[6:0], 1'b0};
        end
        return p;
    endfunction

    function automatic int pdeg(logic [15:0] v);
        int d;
        d = 0;
        while (d < 15 && (v >> (d + 1)) != 0) d++;
        return d;
    endfunction

    // Extended Euclid over GF(2)[x]. Quotients are cut to 8 bits before the
    // multiply, and whatever value the loop ends on is used as is.
    function automatic logic [7:0] finv(logic [7:0] b);
        logic [15:0] r0, r1, r2, q;
        logic [7:0]  w0, w1, w2;
        int sh;
        if (b == 8'h00) return 8'h00;
        r0 = {7'b0, FIELD_POLY};
        r1 = {8'h00, b};
        w0 = 8'h00;
        w1 = 8'h01;
        forever
        begin
            q = 16'h0;
            r2 = r0;
            while (r2 >= r1)
            begin
                sh = pdeg(r2) - pdeg(r1);
                q |= 16'h1 << sh;
                r2 ^= r1 << sh;
            end
            w2 = w0 ^ fmul(q[7:0], w1);
            if (r2 == 16'h0) return w1;
            r0 = r1;
            r1 = r2;
            w0 = w1;
            w1 = w2;
        end
    endfunction

    task automatic build_boxes();
        logic [7:0] a, r, x;
        for (int v = 0; v < 256; v++)
        begin
            x = 8'(v);
            a = finv(x);
            for (int i = 0; i < 8; i++)
                r[i] = a[i] ^ a[(i + 4) % 8] ^ a[(i + 5) % 8] ^ a[(i + 6) % 8]
                     ^ a[(i + 7) % 8] ^ (((8'h63 >> i) & 8'h01) != 0);
            fwd_box[v] = r;
            for (int i = 0; i < 8; i++)
                r[i] = x[(i + 2) % 8] ^ x[(i + 5) % 8] ^ x[(i + 7) % 8]
                     ^ (((8'h05 >> i) & 8'h01) != 0);
            rev_box[v] = finv(r);
        end
    endtask

    task automatic expand_key_schedule();
        logic [31:0] w [4 * (NUM_ROUNDS + 1)];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        w[0] = key_hi_m[63:32];
        w[1] = key_hi_m[31:0];
        w[2] = key_lo_m[63:32];
        w[3] = key_lo_m[31:0];
        for (int i = 4; i < 4 * (NUM_ROUNDS + 1); i++)
        begin
            t = w[i - 1];
            if (i % 4 == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {fwd_box[t[31:24]], fwd_box[t[23:16]], fwd_box[t[15:8]],
                     fwd_box[t[7:0]]} ^ {rc, 24'h0};
                rc = fmul(rc, 8'h02);
            end
            w[i] = w[i - 4] ^ t;
        end
        for (int r = 0; r <= NUM_ROUNDS; r++)
            for (int k = 0; k < 16; k++)
                rk_bytes[r][k] = w[4 * r + k / 4][31 - 8 * (k % 4) -: 8];
        rk_valid = 1;
    endtask

    function automatic void add_round_key(ref logic [7:0] s [16], input int r);
        for (int k = 0; k < 16; k++) s[k] ^= rk_bytes[r][k];
    endfunction

    function automatic void rotate_rows(ref logic [7:0] s [16], input bit back);
        logic [7:0] t [16];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[r + 4 * c] = s[r + 4 * (back ? (c + 4 - r) % 4 : (c + r) % 4)];
        s = t;
    endfunction

    function automatic void mix_cols(ref logic [7:0] s [16], input bit back);
        logic [7:0] m [4];
        logic [7:0] a [4];
        logic [7:0] v;
        if (back)
            m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++)
        begin
            for (int j = 0; j < 4; j++) a[j] = s[4 * c + j];
            for (int r = 0; r < 4; r++)
            begin
                v = 8'h00;
                for (int j = 0; j < 4; j++) v ^= fmul(m[(j - r + 4) % 4], a[j]);
                s[4 * c + r] = v;
            end
        end
    endfunction

    function automatic void sub_all(ref logic [7:0] s [16], input bit back);
        for (int k = 0; k < 16; k++) s[k] = back ? rev_box[s[k]] : fwd_box[s[k]];
    endfunction

    task automatic cipher_block(input block_beat_t b, output cipher_out_t o);
        logic [7:0] s [16];
        if (!rk_valid) expand_key_schedule();
        for (int k = 0; k < 8; k++)
        begin
            s[k] = b.hi[63 - 8 * k -: 8];
            s[k + 8] = b.lo[63 - 8 * k -: 8];
        end
        if (b.op == CMD_ENC)
        begin
            add_round_key(s, 0);
            for (int r = 1; r < NUM_ROUNDS; r++)
            begin
                sub_all(s, 0);
                rotate_rows(s, 0);
                mix_cols(s, 0);
                add_round_key(s, r);
            end
            sub_all(s, 0);
            rotate_rows(s, 0);
            add_round_key(s, NUM_ROUNDS);
        end
        else
        begin
            add_round_key(s, NUM_ROUNDS);
            for (int r = NUM_ROUNDS - 1; r >= 1; r--)
            begin
                rotate_rows(s, 1);
                sub_all(s, 1);
                add_round_key(s, r);
                mix_cols(s, 1);
            end
            rotate_rows(s, 1);
            sub_all(s, 1);
            add_round_key(s, 0);
        end
        for (int k = 0; k < 8; k++)
        begin
            o.hi[63 - 8 * k -: 8] = s[k];
            o.lo[63 - 8 * k -: 8] = s[k + 8];
        end
    endtask

    // ---------------------------------------------------------------- bench state
    block_beat_t pending_blocks [$];
    cipher_out_t expected_blocks [$];
    int  error_count = 0;
    int  idle_cycles = 0;
    bit  hold_input;
    bit  timed_out = 1'b0;

    // Mostly short gaps, now and then a long one; zero often.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------- driver
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            cmd        <= CMD_ENC;
            block_high <= '0;
            block_low  <= '0;
            send_gap   = 0;
        end
        else
        begin
            block_beat_t b;
            cipher_out_t o;
            // A beat accepted on this edge: predict it, then free the channel.
            if (in_valid && in_ready)
            begin
                cipher_block(block_beat_t'{cmd, block_high, block_low}, o);
                expected_blocks.push_back(o);
                send_gap = pick_gap();
            end
            if (!(in_valid && !in_ready))
            begin
                if (send_gap > 0 || hold_input || pending_blocks.size() == 0)
                begin
                    if (send_gap > 0) send_gap--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    b = pending_blocks.pop_front();
                    in_valid   <= 1'b1;
                    cmd        <= b.op;
                    block_high <= b.hi;
                    block_low  <= b.lo;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            cipher_out_t exp_o;
            if (out_valid && out_ready)
            begin
                if (expected_blocks.size() == 0)
                begin
                    $error("unexpected result beat %h_%h", result_high, result_low);
                    error_count++;
                end
                else
                begin
                    exp_o = expected_blocks.pop_front();
                    if (result_high !== exp_o.hi)
                    begin
                        $error("result_high expected %h actual %h", exp_o.hi, result_high);
                        error_count++;
                    end
                    if (result_low !== exp_o.lo)
                    begin
                        $error("result_low expected %h actual %h", exp_o.lo, result_low);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap();
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles with no beat accepted on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
            timed_out <= 1'b1;
    end

    // ---------------------------------------------------------------- sequence
    task automatic write_key(input logic [0:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_KEY_HIGH) key_hi_m = val;
        else key_lo_m = val;
        rk_valid = 0;
    endtask

    // Sampled mid-cycle so queue and handshake updates of the edge have settled.
    task automatic wait_idle();
        while (pending_blocks.size() != 0 || in_valid || expected_blocks.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic queue_block(input logic op, input logic [63:0] h, input logic [63:0] l);
        pending_blocks.push_back(block_beat_t'{op, h, l});
    endtask

    initial
    begin
        logic [63:0] kh, kl, h, l;
        cfg_valid   = 1'b0;
        cfg_index   = REG_KEY_HIGH;
        cfg_data    = '0;
        rst_n       = 1'b0;
        hold_input  = 1'b0;
        key_hi_m    = '0;
        key_lo_m    = '0;
        rk_valid    = 0;
        build_boxes();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // No key written yet: schedule from the all-zero reset key.
        queue_block(CMD_ENC, '0, '0);
        queue_block(CMD_DEC, '0, '0);
        queue_block(CMD_ENC, '1, '1);
        queue_block(CMD_DEC, '1, '1);
        // bytes 0x00 and 0x01 exercise the inverse corner cases
        queue_block(CMD_ENC, 64'h0001000100010001, 64'h0100010001000100);
        queue_block(CMD_DEC, 64'h0001000100010001, 64'h0100010001000100);
        wait_idle();

        // Extreme keys: first all ones, then the low half cleared to zero.
        write_key(REG_KEY_HIGH, '1);
        write_key(REG_KEY_LOW, '1);
        queue_block(CMD_ENC, '0, '1);
        queue_block(CMD_DEC, '1, '0);
        queue_block(CMD_ENC, 64'h8000000000000000, 64'h0000000000000001);
        queue_block(CMD_DEC, 64'h0123456789abcdef, 64'hfedcba9876543210);
        wait_idle();
        write_key(REG_KEY_LOW, '0);
        queue_block(CMD_ENC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        queue_block(CMD_DEC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        wait_idle();

        // Random phases; each writes a fresh random value to either key half with
        // even odds, then queues random blocks with a random encrypt or decrypt cmd.
        for (int phase = 0; phase < 12; phase++)
        begin
            kh = rand64();
            kl = rand64();
            if ($urandom_range(1)) write_key(REG_KEY_HIGH, kh);
            if ($urandom_range(1)) write_key(REG_KEY_LOW, kl);
            for (int n = 0; n < 50; n++)
            begin
                h = rand64();
                l = rand64();
                queue_block(logic'($urandom_range(1)), h, l);
                // Pause the feed once until the core has drained.
                if (phase == 3 && n == 20)
                begin
                    wait_idle();
                    hold_input = 1'b1;
                    repeat (5) @(posedge clk);
                    hold_input = 1'b0;
                end
            end
            wait_idle();
        end

        wait_idle();
        if (error_count == 0 && expected_blocks.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        wait (timed_out);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
